>>> src/pva_pkg.sv
// Shared types and constants for the polyphonic voice allocator.
package pva_pkg;

    localparam int NOTE_W = 7;
    localparam int CHAN_W = 4;
    localparam int ACT_W  = 2;
    localparam int LCH_W  = 8;

    // input action codes
    localparam logic [ACT_W-1:0] ACT_NOTE_ON  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_NOTE_OFF = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LEARN    = 2'd2;

    // listened channel after reset: matches no 4-bit channel
    localparam logic [LCH_W-1:0] LISTEN_NONE = 8'hFF;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_ALLOC,
        OP_RELEASE,
        OP_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [NOTE_W-1:0] note;
        logic [NOTE_W-1:0] velocity;
    } t_cell_cmd;

    typedef struct packed {
        logic              busy;
        logic [NOTE_W-1:0] note;
        logic [NOTE_W-1:0] velocity;
    } t_voice;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

endpackage

>>> src/pva_cell.sv
// One voice cell of the allocator ring: busy flag, held note and velocity.
module pva_cell
    import pva_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  logic      i_claim,
    input  t_voice    i_next,
    output t_voice    o_voice,
    output logic      o_claim
);

    logic              r_busy;
    logic [NOTE_W-1:0] r_note;
    logic [NOTE_W-1:0] r_velocity;
    logic              n_busy;
    logic [NOTE_W-1:0] n_note;
    logic [NOTE_W-1:0] n_velocity;
    logic              w_take;

    // a lower voice already free takes the note first
    assign w_take  = (i_cmd.op == OP_ALLOC) && !i_claim && !r_busy;
    assign o_claim = i_claim || !r_busy;

    // next cell contents
    always_comb begin
        n_busy     = r_busy;
        n_note     = r_note;
        n_velocity = r_velocity;
        case (i_cmd.op)
            OP_CLEAR: begin
                n_busy = 1'b0;
            end
            OP_ALLOC: begin
                if (w_take) begin
                    n_busy     = 1'b1;
                    n_note     = i_cmd.note;
                    n_velocity = i_cmd.velocity;
                end
            end
            OP_RELEASE: begin
                if (r_busy && (r_note == i_cmd.note)) n_busy = 1'b0;
            end
            OP_ROTATE: begin
                n_busy     = i_next.busy;
                n_note     = i_next.note;
                n_velocity = i_next.velocity;
            end
            default: ;
        endcase
    end

    // busy flag is control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_busy <= 1'b0;
        else          r_busy <= n_busy;
    end

    // payload, undefined until written
    always_ff @(posedge i_clk) begin
        r_note     <= n_note;
        r_velocity <= n_velocity;
    end

    assign o_voice.busy     = r_busy;
    assign o_voice.note     = r_note;
    assign o_voice.velocity = r_velocity;

endmodule

>>> src/poly_voice_allocator.sv
// Top level of the polyphonic voice allocator: decode, voice ring and readout.
//
//  channel | direction | handshake            | beat
//  --------+-----------+----------------------+-----------------------------------
//  event   | in        | start high, busy low | action, channel, note, velocity
//  voices  | out       | o_valid strobe       | voice, gate, note, velocity, flags
//
// The event is applied at the edge that accepts it; the readout that follows
// shows one beat per voice, voice 0 first, while the ring of cells rotates one
// place a cycle and so restores itself. Reset frees all voices, clears learn
// mode and the base note and sets the listened channel to none. The receiver
// cannot stall; busy covers the readout.
module poly_voice_allocator
    import pva_pkg::*;
#(
    parameter int VOICES = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [ACT_W-1:0]          i_action,
    input  logic [CHAN_W-1:0]         i_channel,
    input  logic [NOTE_W-1:0]         i_note,
    input  logic [NOTE_W-1:0]         i_velocity,
    output logic                      o_valid,
    output logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] o_voice,
    output logic                      o_gate,
    output logic [NOTE_W-1:0]         o_voice_note,
    output logic [NOTE_W-1:0]         o_voice_velocity,
    output logic                      o_learning,
    output logic [NOTE_W-1:0]         o_base_note_out,
    output logic                      o_last
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [VW-1:0] LAST_IDX = VW'(VOICES - 1);

    t_state            r_state;
    t_state            n_state;
    logic [VW-1:0]     r_count;
    logic [VW-1:0]     n_count;
    logic              r_learn;
    logic              n_learn;
    logic [LCH_W-1:0]  r_listen;
    logic [LCH_W-1:0]  n_listen;
    logic [NOTE_W-1:0] r_base;
    logic [NOTE_W-1:0] n_base;
    logic              w_accept;
    logic              w_match;
    t_cell_cmd         w_cmd;
    t_voice            w_voice [VOICES];
    logic              w_claim [VOICES+1];

    assign w_accept = start && !busy;
    assign w_match  = (r_listen == {{(LCH_W-CHAN_W){1'b0}}, i_channel});

    // next state
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EMIT;
                    n_count = '0;
                end
            end
            ST_EMIT: begin
                n_count = r_count + 1'b1;
                if (r_count == LAST_IDX) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        busy    = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: ;
            ST_EMIT: begin
                busy    = 1'b1;
                o_valid = 1'b1;
            end
            default: ;
        endcase
    end

    // event decode: cell command and global state
    always_comb begin
        w_cmd.op       = OP_HOLD;
        w_cmd.note     = i_note;
        w_cmd.velocity = i_velocity;
        n_learn        = r_learn;
        n_listen       = r_listen;
        n_base         = r_base;
        if (r_state == ST_EMIT) begin
            w_cmd.op = OP_ROTATE;
        end else if (w_accept) begin
            unique case (i_action)
                ACT_NOTE_ON: begin
                    if (r_learn) begin
                        w_cmd.op = OP_CLEAR;
                        n_listen = {{(LCH_W-CHAN_W){1'b0}}, i_channel};
                        n_base   = i_note;
                        n_learn  = 1'b0;
                    end else if (w_match) begin
                        w_cmd.op = OP_ALLOC;
                    end
                end
                ACT_NOTE_OFF: begin
                    if (!r_learn && w_match) w_cmd.op = OP_RELEASE;
                end
                ACT_LEARN: n_learn = !r_learn;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_learn  <= 1'b0;
            r_listen <= LISTEN_NONE;
            r_base   <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_learn  <= n_learn;
            r_listen <= n_listen;
            r_base   <= n_base;
        end
    end

    // voice ring; cell 0 is read out, each cell takes its upper neighbour
    assign w_claim[0] = 1'b0;
    for (genvar g = 0; g < VOICES; g++) begin : g_cell
        pva_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_claim (w_claim[g]),
            .i_next  (w_voice[(g + 1) % VOICES]),
            .o_voice (w_voice[g]),
            .o_claim (w_claim[g+1])
        );
    end

    // result beat
    assign o_voice          = r_count;
    assign o_gate           = w_voice[0].busy && !r_learn;
    assign o_voice_note     = o_gate ? w_voice[0].note : '0;
    assign o_voice_velocity = o_gate ? w_voice[0].velocity : '0;
    assign o_learning       = r_learn;
    assign o_base_note_out  = r_base;
    assign o_last           = (r_count == LAST_IDX);

    // checks
    a_first_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_valid && (o_voice == '0))
        else $error("first beat missing after accept");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !o_valid)
        else $error("readout runs past last voice");

    a_voice_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid && (o_voice == VW'($past(o_voice) + 1'b1)))
        else $error("voice index out of sequence");

    a_learn_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_learning |-> !o_gate && (o_voice_note == '0))
        else $error("gate open during learn mode");

endmodule
